[hdl/dve_pkg.sv]
// Shared constants and types of the difference varint encoder.
`default_nettype none

package dve_pkg;

   localparam int WORD_WIDTH  = 64;
   localparam int GROUP_WIDTH = 7;
   localparam int BYTE_WIDTH  = 8;
   localparam int ORDER_WIDTH = 2;
   localparam int POS_WIDTH   = 2;

   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Difference orders; the code with both bits set behaves as second differences.
   localparam logic [ORDER_WIDTH-1:0] ORDER_PLAIN  = 2'd0;
   localparam logic [ORDER_WIDTH-1:0] ORDER_FIRST  = 2'd1;
   localparam logic [ORDER_WIDTH-1:0] ORDER_SECOND = 2'd2;

   // Position of a value inside its block, saturating at the third value.
   localparam logic [POS_WIDTH-1:0] POS_FIRST  = 2'd0;
   localparam logic [POS_WIDTH-1:0] POS_SECOND = 2'd1;
   localparam logic [POS_WIDTH-1:0] POS_LATER  = 2'd2;

   // One zigzag-mapped residual travelling between the front, the queue and the back.
   typedef struct packed {
      logic                  valid;
      logic [WORD_WIDTH-1:0] value;
   } item_type;

endpackage

`default_nettype wire

[hdl/difference_varint_encoder_core.sv]
// Top level of the difference varint encoder: register, front, queue and back.
`default_nettype none

// Each input transfer carries a signed 64-bit value and a block-start flag. The
// difference order register picks the residual: the value, its difference from the
// previous value, or the difference of differences; the first value of a block is
// always sent as it is, and under second differences the second value is sent as a
// plain difference. The residual is zigzag mapped and leaves as 1 to 10 varint
// bytes, least significant group first, bit 7 set on every byte but the last,
// which is also flagged on rsp_last_byte. The byte sender gives one byte per cycle
// while rsp_stall is low; the front takes a new value every cycle while the two-entry
// queue has room, and an item reaches the output through the front's holding
// register, a queue entry and the back's byte register. Write the order register
// only while no item is in flight.
module difference_varint_encoder_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [dve_pkg::WORD_WIDTH-1:0] req_sample_value,
   input  wire logic                                 req_block_start,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [dve_pkg::BYTE_WIDTH-1:0]            rsp_code_byte,
   output logic                                      rsp_last_byte,
   input  wire logic                                 csr_write_enable,
   input  wire logic [dve_pkg::ORDER_WIDTH-1:0]      csr_write_data
);

   logic [dve_pkg::ORDER_WIDTH-1:0] order_ff, order_in;
   dve_pkg::item_type               push_item;
   dve_pkg::item_type               head_item;
   logic                            push_full;
   logic                            pop;

   assign order_in = csr_write_enable ? csr_write_data : order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= dve_pkg::ORDER_PLAIN;
      end else begin
         order_ff <= order_in;
      end
   end

   dve_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_block_start  (req_block_start),
      .difference_order (order_ff),
      .push_item        (push_item),
      .push_full        (push_full)
   );

   dve_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_item (push_item),
      .push_full (push_full),
      .head_item (head_item),
      .pop       (pop)
   );

   dve_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last_byte (rsp_last_byte)
   );

`ifndef NO_ASSERTIONS
   // A byte that is not the last of its varint is always followed by another.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_byte) |=> rsp_valid)
      else $error("varint cut short after a non-final byte");

   // The continuation bit and the last-byte flag must always disagree.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code_byte[dve_pkg::BYTE_WIDTH-1] != rsp_last_byte))
      else $error("continuation bit inconsistent with last-byte flag");

   // The front holds its item and stalls the input while the queue is full.
   assert property (@(posedge clock) disable iff (reset)
      (push_item.valid && push_full) |-> req_stall)
      else $error("front did not stall on a full queue");

   // The queue is never popped while empty.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_item.valid)
      else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

[hdl/dve_front.sv]
// Front end: takes input transfers, forms the residual and zigzag maps it.
`default_nettype none

module dve_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [dve_pkg::WORD_WIDTH-1:0] req_sample_value,
   input  wire logic                                 req_block_start,
   input  wire logic [dve_pkg::ORDER_WIDTH-1:0]      difference_order,
   output dve_pkg::item_type                         push_item,
   input  wire logic                                 push_full
);

   logic                            a_valid_ff, a_valid_in;
   logic [dve_pkg::WORD_WIDTH-1:0]  a_sample_ff, a_sample_in;
   logic [dve_pkg::WORD_WIDTH-1:0]  a_diff_ff, a_diff_in;
   logic [dve_pkg::POS_WIDTH-1:0]   a_pos_ff, a_pos_in;
   logic [dve_pkg::WORD_WIDTH-1:0]  prev_sample_ff, prev_sample_in;
   logic [dve_pkg::WORD_WIDTH-1:0]  prev_diff_ff, prev_diff_in;
   logic [dve_pkg::POS_WIDTH-1:0]   pos_ff, pos_in;

   logic                            accept;
   logic                            advance;
   logic [dve_pkg::POS_WIDTH-1:0]   pos_cur;
   logic [dve_pkg::WORD_WIDTH-1:0]  residual;
   logic [dve_pkg::WORD_WIDTH-1:0]  mapped;

   assign req_stall = a_valid_ff && push_full;
   assign accept    = req_valid && !req_stall;
   assign advance   = a_valid_ff && !push_full;
   assign pos_cur   = req_block_start ? dve_pkg::POS_FIRST : pos_ff;

   // The first difference is taken on entry; the history of differences moves
   // on only when the held item leaves, so the next item sees its predecessor.
   always_comb begin
      a_valid_in     = a_valid_ff;
      a_sample_in    = a_sample_ff;
      a_diff_in      = a_diff_ff;
      a_pos_in       = a_pos_ff;
      prev_sample_in = prev_sample_ff;
      prev_diff_in   = prev_diff_ff;
      pos_in         = pos_ff;
      if (advance) begin
         a_valid_in   = 1'b0;
         prev_diff_in = (a_pos_ff == dve_pkg::POS_FIRST) ? '0 : a_diff_ff;
      end
      if (accept) begin
         a_valid_in     = 1'b1;
         a_sample_in    = req_sample_value;
         a_diff_in      = req_sample_value - prev_sample_ff;
         a_pos_in       = pos_cur;
         prev_sample_in = req_sample_value;
         pos_in         = (pos_cur == dve_pkg::POS_LATER) ? dve_pkg::POS_LATER
                                                          : pos_cur + 2'd1;
      end
   end

   always_comb begin
      if (difference_order == dve_pkg::ORDER_PLAIN || a_pos_ff == dve_pkg::POS_FIRST) begin
         residual = a_sample_ff;
      end else if (difference_order == dve_pkg::ORDER_FIRST ||
                   a_pos_ff == dve_pkg::POS_SECOND) begin
         residual = a_diff_ff;
      end else begin
         residual = a_diff_ff - prev_diff_ff;
      end
   end

   assign mapped    = {residual[dve_pkg::WORD_WIDTH-2:0], 1'b0}
                      ^ {dve_pkg::WORD_WIDTH{residual[dve_pkg::WORD_WIDTH-1]}};
   assign push_item = '{valid: a_valid_ff, value: mapped};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         prev_sample_ff <= '0;
         prev_diff_ff   <= '0;
         pos_ff         <= dve_pkg::POS_FIRST;
      end else begin
         a_valid_ff     <= a_valid_in;
         prev_sample_ff <= prev_sample_in;
         prev_diff_ff   <= prev_diff_in;
         pos_ff         <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sample_ff <= a_sample_in;
      a_diff_ff   <= a_diff_in;
      a_pos_ff    <= a_pos_in;
   end

endmodule

`default_nettype wire

[hdl/dve_queue.sv]
// Short first-in first-out queue of mapped residuals between front and back.
`default_nettype none

module dve_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dve_pkg::item_type push_item,
   output logic                   push_full,
   output dve_pkg::item_type      head_item,
   input  wire logic              pop
);

   logic [dve_pkg::WORD_WIDTH-1:0]        entries_ff [dve_pkg::QUEUE_DEPTH];
   logic [dve_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dve_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dve_pkg::QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                                  do_push;
   logic                                  do_pop;

   assign push_full = count_ff == dve_pkg::QUEUE_COUNT_WIDTH'(dve_pkg::QUEUE_DEPTH);
   assign head_item = '{valid: count_ff != '0, value: entries_ff[rd_ptr_ff]};

   assign do_push = push_item.valid && !push_full;
   assign do_pop  = pop && head_item.valid;

   // The depth is a power of two, so the pointers wrap on their own.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item.value;
      end
   end

endmodule

`default_nettype wire

[hdl/dve_back.sv]
// Back end: sends mapped residuals as base-128 varint bytes, one per unstalled cycle.
`default_nettype none

module dve_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire dve_pkg::item_type               head_item,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [dve_pkg::BYTE_WIDTH-1:0]       rsp_code_byte,
   output logic                                 rsp_last_byte
);

   logic                           valid_ff, valid_in;
   logic [dve_pkg::WORD_WIDTH-1:0] rest_ff, rest_in;
   logic                           more;
   logic                           transfer;
   logic                           done;

   // The register holds the groups not yet sent; the byte shown is its lowest group.
   assign more          = |rest_ff[dve_pkg::WORD_WIDTH-1:dve_pkg::GROUP_WIDTH];
   assign rsp_valid     = valid_ff;
   assign rsp_code_byte = {more, rest_ff[dve_pkg::GROUP_WIDTH-1:0]};
   assign rsp_last_byte = !more;

   assign transfer = valid_ff && !rsp_stall;
   assign done     = transfer && !more;
   assign pop      = head_item.valid && (!valid_ff || done);

   always_comb begin
      valid_in = valid_ff;
      rest_in  = rest_ff;
      if (pop) begin
         valid_in = 1'b1;
         rest_in  = head_item.value;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (transfer) begin
         rest_in = rest_ff >> dve_pkg::GROUP_WIDTH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
   end

endmodule

`default_nettype wire
